[rtl/tcdt_pkg.sv]
// ----------------------------------------------------------------------------
// tcdt_pkg
// Shared types and constants of the touch contact damage tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tcdt_pkg;

  localparam int CONTACT_SLOTS = 16;
  localparam int SLOT_W        = (CONTACT_SLOTS > 1) ? $clog2(CONTACT_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CONTACT_SLOTS - 1);

  // Stream widths
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 56;

  // Config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_SURF_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURF_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 2'd2;

  localparam logic [12:0] SURF_WIDTH_RST  = 13'd1280;
  localparam logic [12:0] SURF_HEIGHT_RST = 13'd800;
  localparam logic [7:0]  RADIUS_RST      = 8'd40;

  // Request codes
  localparam logic [2:0] REQ_DOWN       = 3'd0;
  localparam logic [2:0] REQ_UP         = 3'd1;
  localparam logic [2:0] REQ_MOTION     = 3'd2;
  localparam logic [2:0] REQ_CANCEL     = 3'd3;
  localparam logic [2:0] REQ_FRAME_DONE = 3'd4;
  localparam logic [2:0] REQ_SURF_RESET = 3'd5;

  localparam logic [11:0] EDGE_MAX = 12'd4095;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_CLAIM,
    ST_REQUEST,
    ST_RD_SCAN,
    ST_CLAMP,
    ST_EMIT
  } tcdt_state_t;

  typedef struct packed {
    logic load;
    logic cnt_clr;
    logic scan;
    logic claim;
    logic frame_done;
    logic surf_reset;
    logic set_pending;
    logic rd_step;
    logic clamp;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       last_slot;
    logic       last_step;
    logic       claim_ok;
    logic       in_flight;
    logic       pending;
    logic       out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[rtl/tcdt_datapath.sv]
// ----------------------------------------------------------------------------
// tcdt_datapath
// Contact table, snapshot, redraw bounding box accumulator, clamp and
// output register of the damage tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module tcdt_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire tcdt_pkg::dp_cmd_t                cmd,
  output tcdt_pkg::dp_sts_t                     sts,
  input  wire logic [tcdt_pkg::IN_DATA_W-1:0]   s_tdata,
  input  wire logic [tcdt_pkg::IN_USER_W-1:0]   s_tuser,
  input  wire logic                             cfg_wr,
  input  wire logic [tcdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tcdt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [tcdt_pkg::OUT_DATA_W-1:0]       m_tdata
);
  import tcdt_pkg::*;

  // Config registers
  logic [12:0] surface_width;
  logic [12:0] surface_height;
  logic [7:0]  circle_radius;

  // Latched request
  logic [2:0]         req_q;
  logic [15:0]        id_q;
  logic signed [15:0] x_q;
  logic signed [15:0] y_q;

  // Contact table and snapshot
  logic [15:0]              slot_id     [CONTACT_SLOTS];
  logic signed [15:0]       slot_x      [CONTACT_SLOTS];
  logic signed [15:0]       slot_y      [CONTACT_SLOTS];
  logic [CONTACT_SLOTS-1:0] slot_active;
  logic signed [15:0]       prev_x      [CONTACT_SLOTS];
  logic signed [15:0]       prev_y      [CONTACT_SLOTS];
  logic [CONTACT_SLOTS-1:0] prev_active;

  logic frame_in_flight;
  logic redraw_pending;
  logic buffer_toggle;

  // Scan control
  logic [SLOT_W:0]   cnt;
  logic [SLOT_W-1:0] scan_idx;
  logic [SLOT_W-1:0] rd_idx;
  logic              rd_cur;
  logic              match_found;
  logic              free_found;
  logic [SLOT_W-1:0] match_idx;
  logic [SLOT_W-1:0] free_idx;
  logic [SLOT_W-1:0] claim_idx;
  logic              hit;

  // Box accumulator
  logic               any;
  logic signed [17:0] x0, y0, x1, y1;
  logic signed [17:0] cx0, cy0, cx1, cy1;
  logic               rd_act;
  logic signed [17:0] rd_px, rd_py, rad, lo_x, hi_x, lo_y, hi_y;
  logic signed [17:0] wm1, hm1;
  logic signed [17:0] bx0, by0, bx1, by1;

  // Emit
  logic signed [17:0] dw, dh, ex, ey;
  logic [12:0]        dw_o, dh_o;
  logic [11:0]        ex_o, ey_o;

  assign scan_idx  = cnt[SLOT_W-1:0];
  assign rd_idx    = cnt[SLOT_W:1];
  assign rd_cur    = cnt[0];
  assign hit       = slot_active[scan_idx] && (slot_id[scan_idx] == id_q);
  assign claim_idx = match_found ? match_idx : free_idx;

  assign rad = {10'd0, circle_radius};
  assign wm1 = {5'd0, surface_width} - 18'sd1;
  assign hm1 = {5'd0, surface_height} - 18'sd1;

  always_comb begin
    rd_act = rd_cur ? slot_active[rd_idx] : prev_active[rd_idx];
    rd_px  = 18'(rd_cur ? slot_x[rd_idx] : prev_x[rd_idx]);
    rd_py  = 18'(rd_cur ? slot_y[rd_idx] : prev_y[rd_idx]);
    lo_x   = rd_px - rad;
    hi_x   = rd_px + rad;
    lo_y   = rd_py - rad;
    hi_y   = rd_py + rad;
  end

  // Clamp stage inputs: empty set damages the whole surface
  always_comb begin
    if (any) begin
      bx0 = x0;
      by0 = y0;
      bx1 = x1;
      by1 = y1;
    end else begin
      bx0 = '0;
      by0 = '0;
      bx1 = wm1;
      by1 = hm1;
    end
  end

  always_comb begin
    dw = cx1 - cx0 + 18'sd1;
    dh = cy1 - cy0 + 18'sd1;
    dw_o = (dw < 0) ? 13'd0 : dw[12:0];
    dh_o = (dh < 0) ? 13'd0 : dh[12:0];
    ex = (cx0 > wm1) ? wm1 : cx0;
    if (ex < 0) ex = '0;
    ey = (cy0 > hm1) ? hm1 : cy0;
    if (ey < 0) ey = '0;
    ex_o = (ex > 18'sd4095) ? EDGE_MAX : ex[11:0];
    ey_o = (ey > 18'sd4095) ? EDGE_MAX : ey[11:0];
  end

  always_comb begin
    sts.req       = req_q;
    sts.last_slot = (scan_idx == LAST_SLOT);
    sts.last_step = (rd_idx == LAST_SLOT) && rd_cur;
    sts.claim_ok  = match_found || free_found;
    sts.in_flight = frame_in_flight;
    sts.pending   = redraw_pending;
    sts.out_free  = !m_tvalid || m_tready;
  end

  // Config
  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= SURF_WIDTH_RST;
      surface_height <= SURF_HEIGHT_RST;
      circle_radius  <= RADIUS_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_SURF_WIDTH:  surface_width  <= cfg_data;
        CFG_SURF_HEIGHT: surface_height <= cfg_data;
        CFG_RADIUS:      circle_radius  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= s_tuser;
      id_q  <= s_tdata[15:0];
      x_q   <= s_tdata[31:16];
      y_q   <= s_tdata[47:32];
    end
  end

  // Counter and scan results
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (cmd.cnt_clr) begin
      cnt         <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      if (cmd.scan || cmd.rd_step) cnt <= cnt + 1'b1;
      if (cmd.scan && (req_q == REQ_DOWN)) begin
        if (hit && !match_found) begin
          match_found <= 1'b1;
          match_idx   <= scan_idx;
        end
        if (!slot_active[scan_idx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= scan_idx;
        end
      end
    end
  end

  // Table active bits and snapshot active bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
      prev_active <= '0;
    end else begin
      if (cmd.scan) begin
        case (req_q)
          REQ_UP:     if (hit) slot_active[scan_idx] <= 1'b0;
          REQ_CANCEL: slot_active[scan_idx] <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.claim) slot_active[claim_idx] <= 1'b1;
      if (cmd.rd_step && rd_cur) prev_active[rd_idx] <= slot_active[rd_idx];
      if (cmd.surf_reset) prev_active <= '0;
    end
  end

  // Table payload and snapshot payload
  always_ff @(posedge clk) begin
    if (cmd.scan && (req_q == REQ_MOTION) && hit) begin
      slot_x[scan_idx] <= x_q;
      slot_y[scan_idx] <= y_q;
    end
    if (cmd.claim) begin
      slot_id[claim_idx] <= id_q;
      slot_x[claim_idx]  <= x_q;
      slot_y[claim_idx]  <= y_q;
    end
    if (cmd.rd_step && rd_cur) begin
      prev_x[rd_idx] <= slot_x[rd_idx];
      prev_y[rd_idx] <= slot_y[rd_idx];
    end
  end

  // Bounding box accumulator and clamp stage
  always_ff @(posedge clk) begin
    if (rst) begin
      any <= 1'b0;
    end else if (cmd.cnt_clr) begin
      any <= 1'b0;
    end else if (cmd.rd_step && rd_act) begin
      any <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_step && rd_act) begin
      if (!any || lo_x < x0) x0 <= lo_x;
      if (!any || lo_y < y0) y0 <= lo_y;
      if (!any || hi_x > x1) x1 <= hi_x;
      if (!any || hi_y > y1) y1 <= hi_y;
    end
    if (cmd.clamp) begin
      cx0 <= (bx0 < 0) ? 18'sd0 : bx0;
      cy0 <= (by0 < 0) ? 18'sd0 : by0;
      cx1 <= (bx1 > wm1) ? wm1 : bx1;
      cy1 <= (by1 > hm1) ? hm1 : by1;
    end
  end

  // Frame flags
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_in_flight <= 1'b0;
      redraw_pending  <= 1'b0;
      buffer_toggle   <= 1'b0;
    end else begin
      if (cmd.frame_done) begin
        frame_in_flight <= 1'b0;
        redraw_pending  <= 1'b0;
      end
      if (cmd.surf_reset) begin
        frame_in_flight <= 1'b0;
        redraw_pending  <= 1'b0;
        buffer_toggle   <= 1'b0;
      end
      if (cmd.set_pending) redraw_pending <= 1'b1;
      if (cmd.emit) begin
        frame_in_flight <= 1'b1;
        buffer_toggle   <= ~buffer_toggle;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {5'd0, buffer_toggle, dh_o, dw_o, ey_o, ex_o};
    end
  end

endmodule

`default_nettype wire

[rtl/tcdt_ctrl.sv]
// ----------------------------------------------------------------------------
// tcdt_ctrl
// Sequencer of the damage tracker: table scan, slot claim, redraw gating,
// redraw scan, clamp and emit.
// ----------------------------------------------------------------------------
`default_nettype none

module tcdt_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire tcdt_pkg::dp_sts_t    sts,
  output tcdt_pkg::dp_cmd_t         cmd
);
  import tcdt_pkg::*;

  tcdt_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        case (sts.req) inside
          REQ_DOWN, REQ_UP, REQ_MOTION, REQ_CANCEL: state_next = ST_SCAN;
          REQ_FRAME_DONE: state_next = sts.pending ? ST_RD_SCAN : ST_IDLE;
          REQ_SURF_RESET: state_next = ST_RD_SCAN;
          default:        state_next = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (sts.last_slot) state_next = (sts.req == REQ_DOWN) ? ST_CLAIM : ST_REQUEST;
      end
      ST_CLAIM: begin
        state_next = sts.claim_ok ? ST_REQUEST : ST_IDLE;
      end
      ST_REQUEST: begin
        state_next = sts.in_flight ? ST_IDLE : ST_RD_SCAN;
      end
      ST_RD_SCAN: begin
        if (sts.last_step) state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DECODE: begin
        cmd.cnt_clr    = 1'b1;
        cmd.frame_done = (sts.req == REQ_FRAME_DONE);
        cmd.surf_reset = (sts.req == REQ_SURF_RESET);
      end
      ST_SCAN:    cmd.scan = 1'b1;
      ST_CLAIM:   cmd.claim = sts.claim_ok;
      ST_REQUEST: begin
        cmd.cnt_clr     = 1'b1;
        cmd.set_pending = sts.in_flight;
      end
      ST_RD_SCAN: cmd.rd_step = 1'b1;
      ST_CLAMP:   cmd.clamp = 1'b1;
      ST_EMIT:    cmd.emit = sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/touch_contact_damage_tracker.sv]
// ----------------------------------------------------------------------------
// touch_contact_damage_tracker
// Touch contact table with gated redraws that emit a clamped damage box.
// ----------------------------------------------------------------------------
// Flow: down/up/motion/cancel scan all 16 slots, one slot per cycle; unless
// a frame is in flight, a redraw then reads table and snapshot of all 16 slots,
// one entry per cycle, clamps and emits once the output is free. Frame done with
// a pending redraw and surface reset go straight to the redraw. One request at a time.
// Reset: synchronous rst clears the table, snapshot, frame flags and config.
`default_nettype none

module touch_contact_damage_tracker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // contact_id[15:0], pos_x[31:16], pos_y[47:32]
  input  wire logic [tcdt_pkg::IN_DATA_W-1:0]   s_tdata,
  // req_type[2:0]
  input  wire logic [tcdt_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // damage_x[11:0], damage_y[23:12], damage_w[36:24], damage_h[49:37],
  // buffer_select[50], zero[55:51]
  output logic [tcdt_pkg::OUT_DATA_W-1:0]       m_tdata,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tcdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tcdt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tcdt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  tcdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcdt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire

[tb/tb_touch_contact_damage_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_contact_damage_tracker
// Drives touch events into the tracker and checks each damage box it emits
// against a cycle-free model of the contact table, the frame gating and the
// clamping, or against the boxes of a short directed table that runs first;
// then random traffic under several surface and radius settings, mostly with random stalls on both streams.
// ----------------------------------------------------------------------------

module tb_touch_contact_damage_tracker;
  import tcdt_pkg::*;

  localparam logic [2:0] REQ_BAD_A = 3'd6;
  localparam logic [2:0] REQ_BAD_B = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASE_ITEMS   = 80;

  // Same bit order as m_tdata[50:0]: damage_x lowest
  typedef struct packed {
    logic        buf_sel;
    logic [12:0] dmg_h;
    logic [12:0] dmg_w;
    logic [11:0] dmg_y;
    logic [11:0] dmg_x;
  } damage_t;

  typedef struct packed {
    logic [2:0]  rq;
    logic [15:0] id;
    logic [15:0] px;
    logic [15:0] py;
    bit          typed;
    bit          has_box;
    damage_t     box;
  } dir_row_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [IN_USER_W-1:0]  s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  touch_contact_damage_tracker DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Contact table model
  logic [15:0] tbl_id  [CONTACT_SLOTS];
  bit          tbl_on  [CONTACT_SLOTS];
  int          tbl_x   [CONTACT_SLOTS];
  int          tbl_y   [CONTACT_SLOTS];
  bit          snap_on [CONTACT_SLOTS];
  int          snap_x  [CONTACT_SLOTS];
  int          snap_y  [CONTACT_SLOTS];
  bit          in_flight;
  bit          pending;
  bit          buf_sel;
  int          surf_w = SURF_WIDTH_RST;
  int          surf_h = SURF_HEIGHT_RST;
  int          rad    = RADIUS_RST;

  damage_t damage_due [$];
  int      mismatches;
  bit      idle_on;
  int      hold_req;

  // Directed rows. box columns: '{buf, h, w, y, x}
  localparam int DIR_N = 18;
  dir_row_t dir_tbl [DIR_N] = '{
    '{REQ_FRAME_DONE, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, '0},
    '{REQ_DOWN,       16'h0001, 16'd100,  16'd200,  1'b1, 1'b1,
      '{1'b0, 13'd81, 13'd81, 12'd160, 12'd60}},
    '{REQ_MOTION,     16'h0001, 16'd300,  16'd400,  1'b1, 1'b0, '0},
    '{REQ_FRAME_DONE, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1,
      '{1'b1, 13'd281, 13'd281, 12'd160, 12'd60}},
    '{REQ_UP,         16'h0001, 16'h0000, 16'h0000, 1'b1, 1'b0, '0},
    '{REQ_FRAME_DONE, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1,
      '{1'b0, 13'd81, 13'd81, 12'd360, 12'd260}},
    '{REQ_FRAME_DONE, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, '0},
    '{REQ_UP,         16'h0001, 16'h0000, 16'h0000, 1'b1, 1'b1,
      '{1'b1, 13'd800, 13'd1280, 12'd0, 12'd0}},
    '{REQ_SURF_RESET, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1,
      '{1'b0, 13'd800, 13'd1280, 12'd0, 12'd0}},
    '{REQ_FRAME_DONE, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, '0},
    // far off the top left corner: box collapses to nothing
    '{REQ_DOWN,       16'hFFFF, 16'h8000, 16'h8000, 1'b1, 1'b1,
      '{1'b1, 13'd0, 13'd0, 12'd0, 12'd0}},
    '{REQ_FRAME_DONE, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, '0},
    '{REQ_DOWN,       16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1,
      '{1'b0, 13'd800, 13'd1280, 12'd0, 12'd0}},
    '{REQ_BAD_A,      16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0},
    '{REQ_BAD_B,      16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0},
    '{REQ_CANCEL,     16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, '0},
    '{REQ_FRAME_DONE, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1,
      '{1'b1, 13'd800, 13'd1280, 12'd0, 12'd0}},
    // surface reset while a frame is in flight
    '{REQ_SURF_RESET, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1,
      '{1'b0, 13'd800, 13'd1280, 12'd0, 12'd0}}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int clip_edge(input int e, input int size);
    if (e > size - 1) e = size - 1;
    if (e < 0) e = 0;
    if (e > 4095) e = 4095;
    return e;
  endfunction

  // Box around both snapshots, then snapshot the table and flip buffers
  function automatic void paint_box(output damage_t d);
    int x0, y0, x1, y1, dw, dh, px, py;
    bit seen, on;
    seen = 1'b0;
    x0 = 0; y0 = 0; x1 = 0; y1 = 0;
    for (int i = 0; i < CONTACT_SLOTS; i++) begin
      for (int k = 0; k < 2; k++) begin
        on = k ? tbl_on[i] : snap_on[i];
        px = k ? tbl_x[i] : snap_x[i];
        py = k ? tbl_y[i] : snap_y[i];
        if (on) begin
          if (!seen || px - rad < x0) x0 = px - rad;
          if (!seen || py - rad < y0) y0 = py - rad;
          if (!seen || px + rad > x1) x1 = px + rad;
          if (!seen || py + rad > y1) y1 = py + rad;
          seen = 1'b1;
        end
      end
    end
    if (!seen) begin
      x0 = 0; y0 = 0; x1 = surf_w - 1; y1 = surf_h - 1;
    end
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > surf_w - 1) x1 = surf_w - 1;
    if (y1 > surf_h - 1) y1 = surf_h - 1;
    dw = x1 - x0 + 1;
    dh = y1 - y0 + 1;
    if (dw < 0) dw = 0;
    if (dh < 0) dh = 0;
    d.dmg_x   = 12'(clip_edge(x0, surf_w));
    d.dmg_y   = 12'(clip_edge(y0, surf_h));
    d.dmg_w   = 13'(dw);
    d.dmg_h   = 13'(dh);
    d.buf_sel = buf_sel;
    in_flight = 1'b1;
    snap_on = tbl_on;
    snap_x  = tbl_x;
    snap_y  = tbl_y;
    buf_sel = ~buf_sel;
  endfunction

  function automatic bit ask_redraw(output damage_t d);
    d = '0;
    if (!in_flight) begin
      paint_box(d);
      return 1'b1;
    end
    pending = 1'b1;
    return 1'b0;
  endfunction

  function automatic bit apply_touch(input logic [2:0] rq, input logic [15:0] id,
                                     input logic [15:0] px, input logic [15:0] py,
                                     output damage_t d);
    int hit;
    hit = -1;
    d = '0;
    case (rq)
      REQ_DOWN: begin
        for (int i = 0; i < CONTACT_SLOTS && hit < 0; i++)
          if (tbl_on[i] && tbl_id[i] == id) hit = i;
        for (int i = 0; i < CONTACT_SLOTS && hit < 0; i++)
          if (!tbl_on[i]) hit = i;
        if (hit < 0) return 1'b0;  // table full: dropped
        tbl_id[hit] = id;
        tbl_on[hit] = 1'b1;
        tbl_x[hit]  = $signed(px);
        tbl_y[hit]  = $signed(py);
        return ask_redraw(d);
      end
      REQ_UP: begin
        for (int i = 0; i < CONTACT_SLOTS; i++)
          if (tbl_on[i] && tbl_id[i] == id) tbl_on[i] = 1'b0;
        return ask_redraw(d);
      end
      REQ_MOTION: begin
        for (int i = 0; i < CONTACT_SLOTS; i++)
          if (tbl_on[i] && tbl_id[i] == id) begin
            tbl_x[i] = $signed(px);
            tbl_y[i] = $signed(py);
          end
        return ask_redraw(d);
      end
      REQ_CANCEL: begin
        for (int i = 0; i < CONTACT_SLOTS; i++) tbl_on[i] = 1'b0;
        return ask_redraw(d);
      end
      REQ_FRAME_DONE: begin
        in_flight = 1'b0;
        if (pending) begin
          pending = 1'b0;
          paint_box(d);
          return 1'b1;
        end
        return 1'b0;
      end
      REQ_SURF_RESET: begin
        for (int i = 0; i < CONTACT_SLOTS; i++) begin
          snap_on[i] = 1'b0;
          snap_x[i]  = 0;
          snap_y[i]  = 0;
        end
        in_flight = 1'b0;
        pending   = 1'b0;
        buf_sel   = 1'b0;
        return ask_redraw(d);
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < 40) $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic cmp_field(input string name, input int got, input int want);
    if (got != want)
      flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic check_damage(input damage_t got);
    damage_t want;
    if (damage_due.size() == 0) begin
      flag_mismatch("damage transfer with none outstanding");
      return;
    end
    want = damage_due.pop_front();
    cmp_field("damage_x", got.dmg_x, want.dmg_x);
    cmp_field("damage_y", got.dmg_y, want.dmg_y);
    cmp_field("damage_w", got.dmg_w, want.dmg_w);
    cmp_field("damage_h", got.dmg_h, want.dmg_h);
    cmp_field("buffer_select", got.buf_sel, want.buf_sel);
  endtask

  // Called at a rising edge; returns at the edge of the transfer
  task automatic offer(input logic [2:0] rq, input logic [15:0] id,
                       input logic [15:0] px, input logic [15:0] py,
                       input bit typed, input bit has_box, input damage_t box);
    int gap;
    bit made;
    damage_t d;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= rq;
    s_tdata  <= {py, px, id};
    do @(posedge clk); while (!s_tready);
    made = apply_touch(rq, id, px, py, d);
    if (typed) begin
      if (has_box) damage_due.push_back(box);
    end else if (made) begin
      damage_due.push_back(d);
    end
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [12:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SURF_WIDTH:  surf_w = val;
      CFG_SURF_HEIGHT: surf_h = val;
      CFG_RADIUS:      rad    = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (damage_due.size() != 0) @(posedge clk);
    // events that make no box may still be in the pipe
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord(input int span);
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, span + 2 * rad)) - rad);
  endfunction

  task automatic run_random(input int n);
    int sent, pick;
    logic [2:0] rq;
    logic [15:0] id;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      rq = REQ_DOWN;
      else if (pick < 55) rq = REQ_MOTION;
      else if (pick < 70) rq = REQ_UP;
      else if (pick < 92) rq = REQ_FRAME_DONE;
      else if (pick < 95) rq = REQ_CANCEL;
      else if (pick < 98) rq = REQ_SURF_RESET;
      else if (pick < 99) rq = REQ_BAD_A;
      else                rq = REQ_BAD_B;
      // small id pool so that up and motion hit live contacts
      id = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 19));
      offer(rq, id, rand_coord(surf_w), rand_coord(surf_h), 1'b0, 1'b0, '0);
      if (rq != REQ_BAD_A && rq != REQ_BAD_B) sent++;
    end
  endtask

  // Result side: random stalls, plus one long hold on request
  initial begin : sink
    int stall;
    stall = 0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        check_damage(damage_t'(m_tdata[50:0]));
        if (idle_on) stall = $urandom_range(0, 7);
      end
    end
  end

  initial begin : stim
    mismatches = 0;
    idle_on    = 1'b1;
    hold_req   = 0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_N; r++)
      offer(dir_tbl[r].rq, dir_tbl[r].id, dir_tbl[r].px, dir_tbl[r].py,
            dir_tbl[r].typed, dir_tbl[r].has_box, dir_tbl[r].box);
    // fill every slot, then one more down that must be dropped
    for (int i = 0; i < CONTACT_SLOTS; i++)
      offer(REQ_DOWN, 16'(16'h0100 + i), 16'(i * 17), 16'(i * 13), 1'b0, 1'b0, '0);
    offer(REQ_DOWN, 16'h0200, 16'd1000, 16'd700, 1'b0, 1'b0, '0);
    offer(REQ_FRAME_DONE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, '0);
    drain();

    run_random(PHASE_ITEMS);
    drain();

    // smallest surface and radius, no stalls on either side
    idle_on = 1'b0;
    set_reg(CFG_SURF_WIDTH, 13'd1);
    set_reg(CFG_SURF_HEIGHT, 13'd1);
    set_reg(CFG_RADIUS, 13'd1);
    run_random(PHASE_ITEMS);
    drain();

    idle_on = 1'b1;
    set_reg(CFG_SURF_WIDTH, 13'd4096);
    set_reg(CFG_SURF_HEIGHT, 13'd4096);
    set_reg(CFG_RADIUS, 13'd255);
    set_reg(CFG_UNUSED, 13'h1FFF);
    run_random(PHASE_ITEMS);
    drain();

    set_reg(CFG_SURF_WIDTH, 13'($urandom_range(1, 4096)));
    set_reg(CFG_SURF_HEIGHT, 13'($urandom_range(1, 4096)));
    set_reg(CFG_RADIUS, 13'($urandom_range(1, 255)));
    hold_req = HOLD_CYCLES;
    run_random(PHASE_ITEMS);
    drain();

    set_reg(CFG_SURF_WIDTH, 13'd64);
    set_reg(CFG_SURF_HEIGHT, 13'd48);
    set_reg(CFG_RADIUS, 13'($urandom_range(1, 255)));
    run_random(PHASE_ITEMS);
    drain();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
